FILE: hdl/gli_pkg.sv
// Shared constants, types and register codes of the gap linear interpolator.
`default_nettype none

package gli_pkg;

    // Sample and fixed-point widths
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = DATA_W + FRAC_BITS;   // scaled magnitude / step width

    // Record indexing
    localparam int                IDX_W      = 21;
    localparam logic [IDX_W-1:0]  MAX_RECORD = IDX_W'(1048576);

    // Gap holding: gap counter and result count of one command
    localparam int               MAX_GAP = 63;
    localparam int               GAP_W   = 6;
    localparam int               CNT_W   = GAP_W + 1;   // up to MAX_GAP + 1 results

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int          ADDR_W      = 3;
    localparam logic [0:0]  REG_INVALID = 1'b0;
    localparam logic [0:0]  REG_FILL    = 1'b1;
    localparam logic [DATA_W-1:0] INVALID_RESET = 32'h8000_0000;

    // Fill mode bits
    localparam int FILL_LEAD_BIT  = 0;
    localparam int FILL_TRAIL_BIT = 1;

    typedef struct packed {
        logic [DATA_W-1:0] invalid_value;
        logic [1:0]        fill_mode;
    } t_cfg;

    // Record summary, carried on the final result of a record
    typedef struct packed {
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] last_idx;
        logic [IDX_W-1:0] filled;
        logic             no_good;
        logic             overflowed;
    } t_summary;

    // One command: body_cnt body results (repeated or interpolated), then an
    // optional tail result. Its final result closes the item.
    typedef struct packed {
        logic [CNT_W-1:0]  body_cnt;
        logic [DATA_W-1:0] body_val;    // repeated value, or anchor when interpolating
        logic              body_filled;
        logic              body_inval;
        logic              interp;
        logic              tail;
        logic [DATA_W-1:0] tail_val;    // the good sample, also interpolation end point
        logic              done;
        t_summary          sum;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              was_filled;
        logic              left_invalid;
        logic              run_last;
        logic              record_done;
        t_summary          sum;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/gli_front.sv
// Front end: accepts samples, tracks gap and record state; at most one command a beat.
`default_nettype none

module gli_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gli_pkg::t_cfg                i_cfg,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [gli_pkg::DATA_W-1:0]   i_sample_value,
    input  wire logic                         i_record_last,
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output gli_pkg::t_cmd                     o_cmd
);

    logic [gli_pkg::IDX_W-1:0]  r_pos,   n_pos;
    logic [gli_pkg::GAP_W-1:0]  r_gap,   n_gap;
    logic [gli_pkg::DATA_W-1:0] r_anchor, n_anchor;
    logic                       r_seen,  n_seen;
    logic [gli_pkg::IDX_W-1:0]  r_first, n_first;
    logic [gli_pkg::IDX_W-1:0]  r_lastv, n_lastv;
    logic [gli_pkg::IDX_W-1:0]  r_fill,  n_fill;
    logic                       r_broken, n_broken;
    logic                       r_long,  n_long;

    logic                       accept;
    logic                       is_good;
    logic [gli_pkg::CNT_W-1:0]  add_k;
    logic [gli_pkg::IDX_W:0]    fill_sum;
    logic [gli_pkg::IDX_W:0]    len_sum;
    logic [gli_pkg::IDX_W-1:0]  rec_len;
    logic [gli_pkg::GAP_W-1:0]  gap_inc;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_good    = i_sample_value != i_cfg.invalid_value;
    assign gap_inc    = r_gap + gli_pkg::GAP_W'(1);

    // Classify the beat and build its command
    always_comb begin
        n_pos    = r_pos;
        n_gap    = r_gap;
        n_anchor = r_anchor;
        n_seen   = r_seen;
        n_first  = r_first;
        n_lastv  = r_lastv;
        n_fill   = r_fill;
        n_broken = r_broken;
        n_long   = r_long;
        o_cmd    = '0;
        o_push   = 1'b0;
        add_k    = '0;
        fill_sum = '0;
        len_sum  = '0;
        rec_len  = '0;

        if (accept) begin
            if (is_good) begin
                // good sample: release held gap, then the sample itself
                o_push           = 1'b1;
                o_cmd.body_cnt   = gli_pkg::CNT_W'(r_gap);
                o_cmd.tail       = 1'b1;
                o_cmd.tail_val   = i_sample_value;
                if (r_gap != '0) begin
                    if (r_seen) begin
                        o_cmd.interp      = 1'b1;
                        o_cmd.body_val    = r_anchor;
                        o_cmd.body_filled = 1'b1;
                        add_k             = gli_pkg::CNT_W'(r_gap);
                    end else if (i_cfg.fill_mode[gli_pkg::FILL_LEAD_BIT]) begin
                        o_cmd.body_val    = i_sample_value;
                        o_cmd.body_filled = 1'b1;
                        add_k             = gli_pkg::CNT_W'(r_gap);
                    end else begin
                        o_cmd.body_val    = i_cfg.invalid_value;
                        o_cmd.body_inval  = 1'b1;
                    end
                end
                n_gap    = '0;
                n_long   = 1'b0;
                n_anchor = i_sample_value;
                if (!r_seen) begin
                    n_first = r_pos;
                end
                n_seen  = 1'b1;
                n_lastv = r_pos;
            end else begin
                o_cmd.body_val   = i_sample_value;
                o_cmd.body_inval = 1'b1;
                priority if (r_long) begin
                    // rest of a broken gap passes at once
                    o_push         = 1'b1;
                    o_cmd.body_cnt = gli_pkg::CNT_W'(1);
                end else if (!r_seen && r_gap == '0
                             && !i_cfg.fill_mode[gli_pkg::FILL_LEAD_BIT]) begin
                    // leading invalid samples without leading fill
                    o_push         = 1'b1;
                    o_cmd.body_cnt = gli_pkg::CNT_W'(1);
                end else if (r_gap >= gli_pkg::GAP_W'(gli_pkg::MAX_GAP)) begin
                    // gap too long: flush held samples and this one unchanged
                    o_push         = 1'b1;
                    o_cmd.body_cnt = gli_pkg::CNT_W'(r_gap) + gli_pkg::CNT_W'(1);
                    n_gap          = '0;
                    n_long         = 1'b1;
                    n_broken       = 1'b1;
                end else begin
                    n_gap = gap_inc;
                    if (i_record_last) begin
                        // trailing gap closes with the record
                        o_push         = 1'b1;
                        o_cmd.body_cnt = gli_pkg::CNT_W'(gap_inc);
                        if (r_seen && i_cfg.fill_mode[gli_pkg::FILL_TRAIL_BIT]) begin
                            o_cmd.body_val    = r_anchor;
                            o_cmd.body_filled = 1'b1;
                            o_cmd.body_inval  = 1'b0;
                            add_k             = gli_pkg::CNT_W'(gap_inc);
                        end
                        n_gap = '0;
                    end
                end
            end

            // saturating fill count
            fill_sum = {1'b0, r_fill} + (gli_pkg::IDX_W+1)'(add_k);
            n_fill   = (fill_sum > (gli_pkg::IDX_W+1)'(gli_pkg::MAX_RECORD))
                     ? gli_pkg::MAX_RECORD : fill_sum[gli_pkg::IDX_W-1:0];

            if (i_record_last) begin
                // summary, then clear the record state
                len_sum = {1'b0, r_pos} + (gli_pkg::IDX_W+1)'(1);
                rec_len = (len_sum > (gli_pkg::IDX_W+1)'(gli_pkg::MAX_RECORD))
                        ? gli_pkg::MAX_RECORD : len_sum[gli_pkg::IDX_W-1:0];
                o_cmd.done           = 1'b1;
                o_cmd.sum.first_idx  = n_seen ? n_first : rec_len;
                o_cmd.sum.last_idx   = n_seen ? n_lastv : rec_len;
                o_cmd.sum.filled     = n_fill;
                o_cmd.sum.no_good    = !n_seen;
                o_cmd.sum.overflowed = n_broken;
                n_pos    = '0;
                n_gap    = '0;
                n_anchor = '0;
                n_seen   = 1'b0;
                n_first  = '0;
                n_lastv  = '0;
                n_fill   = '0;
                n_broken = 1'b0;
                n_long   = 1'b0;
            end else if (r_pos < gli_pkg::MAX_RECORD) begin
                n_pos = r_pos + gli_pkg::IDX_W'(1);
            end
        end
    end

    // Record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_gap    <= '0;
            r_anchor <= '0;
            r_seen   <= 1'b0;
            r_first  <= '0;
            r_lastv  <= '0;
            r_fill   <= '0;
            r_broken <= 1'b0;
            r_long   <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_gap    <= n_gap;
            r_anchor <= n_anchor;
            r_seen   <= n_seen;
            r_first  <= n_first;
            r_lastv  <= n_lastv;
            r_fill   <= n_fill;
            r_broken <= n_broken;
            r_long   <= n_long;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/gli_queue.sv
// Small command queue between the front end and the back end.
`default_nettype none

module gli_queue #(
    parameter int DEPTH = gli_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gli_pkg::t_cmd  i_cmd,
    output logic                o_full,
    output logic                o_valid,
    output gli_pkg::t_cmd       o_cmd,
    input  wire logic           i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gli_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!do_push && do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/gli_back.sv
// Back end: serial step division, interpolation and result emission.
`default_nettype none

module gli_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire gli_pkg::t_cmd     i_q_cmd,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output gli_pkg::t_result       o_result
);

    localparam int BIT_CNT_W = $clog2(gli_pkg::DIV_W);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_BODY = 4'b0100,
        S_TAIL = 4'b1000
    } t_back_state;

    t_back_state                 r_state, n_state;
    gli_pkg::t_cmd               r_cmd,   n_cmd;
    logic [gli_pkg::CNT_W-1:0]   r_cnt,   n_cnt;
    logic [gli_pkg::CNT_W-1:0]   r_rem,   n_rem;
    logic [gli_pkg::DIV_W-1:0]   r_quo,   n_quo;
    logic [gli_pkg::DIV_W-1:0]   r_step,  n_step;
    logic [gli_pkg::DIV_W-1:0]   r_acc,   n_acc;
    logic                        r_neg,   n_neg;
    logic [BIT_CNT_W-1:0]        r_bit_cnt, n_bit_cnt;
    gli_pkg::t_result            r_out,   n_out;
    logic                        r_out_valid, n_out_valid;

    logic                        out_free;
    logic                        is_final;
    logic [gli_pkg::CNT_W-1:0]   divisor;
    logic [gli_pkg::CNT_W:0]     trial;
    logic [gli_pkg::CNT_W:0]     trial_sub;
    logic                        quo_bit;
    logic [gli_pkg::DATA_W:0]    diff;
    logic [gli_pkg::DATA_W:0]    mag;
    logic                        round_up;
    logic [gli_pkg::DATA_W:0]    q_mag;
    logic [gli_pkg::DATA_W:0]    anchor_ext;
    logic [gli_pkg::DATA_W:0]    interp_val;

    assign out_free = !r_out_valid || i_out_ready;

    // Restoring divider step: one quotient bit per cycle
    assign divisor   = r_cmd.body_cnt + gli_pkg::CNT_W'(1);
    assign trial     = {r_rem, r_quo[gli_pkg::DIV_W-1]};
    assign trial_sub = trial - {1'b0, divisor};
    assign quo_bit   = trial >= {1'b0, divisor};

    // Difference to the next good sample, taken at pop
    assign diff = {i_q_cmd.tail_val[gli_pkg::DATA_W-1], i_q_cmd.tail_val}
                - {i_q_cmd.body_val[gli_pkg::DATA_W-1], i_q_cmd.body_val};
    assign mag  = diff[gli_pkg::DATA_W] ? -diff : diff;

    // Interpolated value: anchor plus floor of the accumulated scaled offset
    assign round_up   = r_neg && (r_acc[gli_pkg::FRAC_BITS-1:0] != '0);
    assign q_mag      = {1'b0, r_acc[gli_pkg::DIV_W-1:gli_pkg::FRAC_BITS]}
                      + (gli_pkg::DATA_W+1)'(round_up);
    assign anchor_ext = {r_cmd.body_val[gli_pkg::DATA_W-1], r_cmd.body_val};
    assign interp_val = r_neg ? anchor_ext - q_mag : anchor_ext + q_mag;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_bit_cnt   = r_bit_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_q_pop     = 1'b0;
        is_final    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_cmd     = i_q_cmd;
                    n_cnt     = i_q_cmd.body_cnt;
                    n_neg     = diff[gli_pkg::DATA_W];
                    n_quo     = {mag[gli_pkg::DATA_W-1:0], gli_pkg::FRAC_BITS'(0)};
                    n_rem     = '0;
                    n_bit_cnt = '0;
                    priority if (i_q_cmd.interp) begin
                        n_state = S_DIV;
                    end else if (i_q_cmd.body_cnt != '0) begin
                        n_state = S_BODY;
                    end else begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_DIV: begin
                n_rem     = quo_bit ? trial_sub[gli_pkg::CNT_W-1:0]
                                    : trial[gli_pkg::CNT_W-1:0];
                n_quo     = {r_quo[gli_pkg::DIV_W-2:0], quo_bit};
                n_bit_cnt = r_bit_cnt + BIT_CNT_W'(1);
                if (r_bit_cnt == BIT_CNT_W'(gli_pkg::DIV_W - 1)) begin
                    n_step  = n_quo;
                    n_acc   = n_quo;
                    n_state = S_BODY;
                end
            end
            S_BODY: begin
                if (out_free) begin
                    is_final           = (r_cnt == gli_pkg::CNT_W'(1)) && !r_cmd.tail;
                    n_out_valid        = 1'b1;
                    n_out.value        = r_cmd.interp ? interp_val[gli_pkg::DATA_W-1:0]
                                                      : r_cmd.body_val;
                    n_out.was_filled   = r_cmd.body_filled;
                    n_out.left_invalid = r_cmd.body_inval;
                    n_out.run_last     = is_final;
                    n_out.record_done  = is_final && r_cmd.done;
                    n_out.sum          = (is_final && r_cmd.done) ? r_cmd.sum : '0;
                    n_cnt              = r_cnt - gli_pkg::CNT_W'(1);
                    n_acc              = r_acc + r_step;
                    if (r_cnt == gli_pkg::CNT_W'(1)) begin
                        n_state = r_cmd.tail ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    is_final           = 1'b1;
                    n_out_valid        = 1'b1;
                    n_out.value        = r_cmd.tail_val;
                    n_out.was_filled   = 1'b0;
                    n_out.left_invalid = 1'b0;
                    n_out.run_last     = 1'b1;
                    n_out.record_done  = r_cmd.done;
                    n_out.sum          = r_cmd.done ? r_cmd.sum : '0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_cnt     <= n_cnt;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_acc     <= n_acc;
        r_neg     <= n_neg;
        r_bit_cnt <= n_bit_cnt;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

FILE: hdl/gap_linear_interpolator_unit.sv
// Gap linear interpolator: top level with configuration registers.
//
// Input channel (i_in_valid / o_in_ready) takes one signed 32-bit sample per
// beat, with i_record_last on the final sample of a record. Samples equal to
// the invalid code are held as a gap of up to 63; the next good sample
// releases the gap, linearly interpolated when a good sample came before,
// then itself. Results leave on the output channel (o_out_valid /
// i_out_ready), several or none per input beat; o_run_last marks the final
// result of a beat, o_record_done the record's. A good sample with no gap
// passes the queue, the back-end command register and the output register.
// An interpolated gap takes a step from a restoring divider giving one
// quotient bit per cycle, then one result per cycle while the receiver is
// ready. The back-end sequencer pops a command, then emits its results.
// A two-entry command queue separates front and back; when the receiver
// stalls, the output register holds, the queue fills and o_in_ready drops.
// Reset (synchronous, i_rst_n low) clears record state and the queue and
// sets invalid code -2^31 and fill mode 0. Write registers only when idle.
`default_nettype none

module gap_linear_interpolator_unit #(
    parameter int QUEUE_DEPTH = gli_pkg::QUEUE_DEPTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [gli_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready,
    // input channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [gli_pkg::DATA_W-1:0]    i_sample_value,
    input  wire logic                                 i_record_last,
    // output channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [gli_pkg::DATA_W-1:0]         o_out_value,
    output logic                                      o_was_filled,
    output logic                                      o_left_invalid,
    output logic                                      o_run_last,
    output logic                                      o_record_done,
    output logic [gli_pkg::IDX_W-1:0]                 o_first_good_index,
    output logic [gli_pkg::IDX_W-1:0]                 o_last_good_index,
    output logic [gli_pkg::IDX_W-1:0]                 o_filled_total,
    output logic                                      o_no_good_data,
    output logic                                      o_gap_overflowed
);

    logic [gli_pkg::DATA_W-1:0] r_invalid_value;
    logic [1:0]                 r_fill_mode;
    logic                       cfg_wr;
    logic [0:0]                 reg_sel;

    gli_pkg::t_cfg              cfg;
    gli_pkg::t_cmd              front_cmd;
    gli_pkg::t_cmd              q_cmd;
    gli_pkg::t_result           result;
    logic                       front_push;
    logic                       q_full;
    logic                       q_valid;
    logic                       q_pop;

    // Register port
    assign pready  = 1'b1;
    assign reg_sel = paddr[gli_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_value <= gli_pkg::INVALID_RESET;
            r_fill_mode     <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                gli_pkg::REG_INVALID: r_invalid_value <= pwdata;
                gli_pkg::REG_FILL:    r_fill_mode     <= pwdata[1:0];
                default:              r_fill_mode     <= r_fill_mode;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            gli_pkg::REG_INVALID: prdata = r_invalid_value;
            gli_pkg::REG_FILL:    prdata = {30'd0, r_fill_mode};
            default:              prdata = '0;
        endcase
    end

    assign cfg.invalid_value = r_invalid_value;
    assign cfg.fill_mode     = r_fill_mode;

    // Front end
    gli_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_record_last  (i_record_last),
        .i_q_full       (q_full),
        .o_push         (front_push),
        .o_cmd          (front_cmd)
    );

    // Command queue
    gli_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Back end
    gli_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    // Result fields
    assign o_out_value        = $signed(result.value);
    assign o_was_filled       = result.was_filled;
    assign o_left_invalid     = result.left_invalid;
    assign o_run_last         = result.run_last;
    assign o_record_done      = result.record_done;
    assign o_first_good_index = result.sum.first_idx;
    assign o_last_good_index  = result.sum.last_idx;
    assign o_filled_total     = result.sum.filled;
    assign o_no_good_data     = result.sum.no_good;
    assign o_gap_overflowed   = result.sum.overflowed;

    // Checks
    a_done_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_record_done) |-> o_run_last)
        else $error("record_done beat without run_last");

    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_record_done) |->
        (o_filled_total == '0 && o_first_good_index == '0 && o_last_good_index == '0
         && !o_no_good_data && !o_gap_overflowed))
        else $error("summary fields set outside record end");

    a_fill_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_was_filled && o_left_invalid))
        else $error("beat both filled and invalid");

    a_no_good_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_record_done && o_no_good_data) |->
        (o_first_good_index == o_last_good_index && o_filled_total == '0))
        else $error("empty record summary inconsistent");

endmodule

`default_nettype wire
